@@ hdl/i8conv_pkg.sv @@
// ----------------------------------------------------------------------------
// i8conv_pkg
// Shared constants, types and control bundles for the int8 convolution block.
// ----------------------------------------------------------------------------
package i8conv_pkg;

    // geometry
    localparam int IN_H      = 14;
    localparam int IN_W      = 14;
    localparam int IN_C      = 6;
    localparam int KERNEL    = 5;
    localparam int OUT_C     = 16;
    localparam int OUT_H     = IN_H - KERNEL + 1;
    localparam int OUT_W     = IN_W - KERNEL + 1;
    localparam int ACT_DEPTH = IN_H * IN_W * IN_C;
    localparam int WGT_DEPTH = KERNEL * KERNEL * IN_C * OUT_C;
    localparam int OUT_COUNT = OUT_H * OUT_W * OUT_C;
    localparam int TAPS      = KERNEL * KERNEL * IN_C;

    // jump of the activation pointer at the end of one kernel row
    localparam int ROW_JUMP  = (IN_W - KERNEL) * IN_C + 1;

    // internal widths
    localparam int ACT_AW = $clog2(ACT_DEPTH);
    localparam int WGT_AW = $clog2(WGT_DEPTH);
    localparam int OCH_W  = $clog2(OUT_C);
    localparam int PIX_W  = $clog2(OUT_H * OUT_W);
    localparam int ROW_W  = $clog2(OUT_H);
    localparam int COL_W  = $clog2(OUT_W);
    localparam int CH_W   = $clog2(IN_C);
    localparam int KC_W   = $clog2(KERNEL);
    localparam int TAP_W  = $clog2(TAPS);

    // field widths
    localparam int ACTION_W  = 2;
    localparam int ADDR_W    = 12;
    localparam int VALUE_W   = 32;
    localparam int OUT_IDX_W = 11;
    localparam int OUT_VAL_W = 8;
    localparam int ADDR_LSB  = 0;
    localparam int VALUE_LSB = ADDR_LSB + ADDR_W;
    localparam int S_TDATA_W = ((ADDR_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_IDX_W + OUT_VAL_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - OUT_IDX_W - OUT_VAL_W;

    // reciprocal division by constants, exact for every index below 2**12
    localparam int DIV_SHIFT   = 24;
    localparam int DIV_W       = OUT_IDX_W + DIV_SHIFT + 1;
    localparam int RECIP_OUT_C = (2 ** DIV_SHIFT + OUT_C - 1) / OUT_C;
    localparam int RECIP_OUT_W = (2 ** DIV_SHIFT + OUT_W - 1) / OUT_W;

    // requantize
    localparam int ACC_W   = 32;
    localparam int PROD_W  = 16;
    localparam int WIDE_W  = 64;
    localparam int SHIFT_W = 6;
    localparam int SAT_MAX = 127;
    localparam int SAT_MIN = -128;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MANTISSA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT    = 1'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_ACT  = 2'd0,
        ACT_WR_WGT  = 2'd1,
        ACT_WR_BIAS = 2'd2,
        ACT_COMPUTE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_CH,
        ST_DIV_POS,
        ST_BASE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic wr_act;
        logic wr_wgt;
        logic wr_bias;
        logic capture;
        logic div_ch;
        logic div_pos;
        logic base;
        logic issue;
        logic mul;
        logic round;
        logic shift;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pos_ok;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

@@ hdl/i8conv_ctrl.sv @@
// ----------------------------------------------------------------------------
// i8conv_ctrl
// Sequencer: decodes input transactions and steps the datapath through
// position decode, the tap loop, drain and requantize.
// ----------------------------------------------------------------------------
module i8conv_ctrl
    import i8conv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ACTION_W-1:0] s_tuser,
    input  status_t             st,
    output cmd_t                cmd
);

    state_t  state_reg, state_next;
    action_t action;
    logic    accept;

    assign action   = action_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (action)
                        ACT_WR_ACT:  cmd.wr_act  = 1'b1;
                        ACT_WR_WGT:  cmd.wr_wgt  = 1'b1;
                        ACT_WR_BIAS: cmd.wr_bias = 1'b1;
                        ACT_COMPUTE: begin
                            cmd.capture = 1'b1;
                            if (st.pos_ok) begin
                                state_next = ST_DIV_CH;
                            end
                        end
                    endcase
                end
            end
            ST_DIV_CH: begin
                cmd.div_ch = 1'b1;
                state_next = ST_DIV_POS;
            end
            ST_DIV_POS: begin
                cmd.div_pos = 1'b1;
                state_next  = ST_BASE;
            end
            ST_BASE: begin
                cmd.base   = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                if (st.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            // wait for the last products, then multiply by the mantissa
            ST_DRAIN: begin
                if (!st.pipe_busy) begin
                    cmd.mul    = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = ST_EMIT;
            end
            // hold until the output register can take the result
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/i8conv_datapath.sv @@
// ----------------------------------------------------------------------------
// i8conv_datapath
// Stores, address generation, the shared multiply-accumulate pipeline,
// requantize stages, configuration registers and the output register.
// ----------------------------------------------------------------------------
module i8conv_datapath
    import i8conv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  cmd_t                  cmd,
    output status_t               st,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // stores
    logic [7:0]       act_mem  [ACT_DEPTH];
    logic [7:0]       wgt_mem  [WGT_DEPTH];
    logic [ACC_W-1:0] bias_mem [OUT_C];

    logic [ADDR_W-1:0]  addr_in;
    logic [VALUE_W-1:0] value_in;

    // configuration
    logic signed [31:0] mant_reg;
    logic [SHIFT_W-1:0] shift_reg;

    // position decode
    logic [OUT_IDX_W-1:0] pos_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [OCH_W-1:0]     och_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [DIV_W-1:0]     ch_prod;
    logic [DIV_W-1:0]     pos_prod;
    logic [PIX_W-1:0]     pix_next;
    logic [OUT_IDX_W-1:0] och_rem;
    logic [ROW_W-1:0]     row_next;
    logic [PIX_W-1:0]     col_rem;

    // tap loop
    logic [ACT_AW-1:0] act_ptr_reg;
    logic [WGT_AW-1:0] wgt_ptr_reg;
    logic [CH_W-1:0]   ch_cnt_reg;
    logic [KC_W-1:0]   kc_cnt_reg;
    logic [TAP_W-1:0]  tap_cnt_reg;
    logic              ch_wrap;
    logic              kc_wrap;
    logic [7:0]        act_q_reg;
    logic [7:0]        wgt_q_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic [ACC_W-1:0]  acc_reg;

    // requantize
    logic signed [ACC_W-1:0]  relu_s;
    logic signed [WIDE_W-1:0] mprod_reg;
    logic signed [WIDE_W-1:0] half_next;
    logic signed [WIDE_W-1:0] sum_reg;
    logic signed [WIDE_W-1:0] shifted_reg;
    logic [OUT_VAL_W-1:0]     out_val_next;

    // output register
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [OUT_VAL_W-1:0] out_val_reg;

    assign addr_in  = s_tdata[ADDR_LSB +: ADDR_W];
    assign value_in = s_tdata[VALUE_LSB +: VALUE_W];

    // store writes, out-of-range addresses are dropped
    always_ff @(posedge aclk) begin
        if (cmd.wr_act && (addr_in < ADDR_W'(ACT_DEPTH))) begin
            act_mem[addr_in[ACT_AW-1:0]] <= value_in[7:0];
        end
        if (cmd.wr_wgt && (addr_in < ADDR_W'(WGT_DEPTH))) begin
            wgt_mem[addr_in[WGT_AW-1:0]] <= value_in[7:0];
        end
        if (cmd.wr_bias && (addr_in < ADDR_W'(OUT_C))) begin
            bias_mem[addr_in[OCH_W-1:0]] <= value_in;
        end
    end

    // store reads, registered
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            act_q_reg <= act_mem[act_ptr_reg];
            wgt_q_reg <= wgt_mem[wgt_ptr_reg];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mant_reg  <= '0;
            shift_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCALE_MANTISSA: mant_reg  <= cfg_wdata;
                CFG_SCALE_SHIFT:    shift_reg <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // position divide by output channels, then by output width
    always_comb begin
        ch_prod  = DIV_W'(pos_reg) * DIV_W'(RECIP_OUT_C);
        pix_next = ch_prod[DIV_SHIFT +: PIX_W];
        och_rem  = pos_reg - OUT_IDX_W'(pix_next * OUT_C);
        pos_prod = DIV_W'(pix_reg) * DIV_W'(RECIP_OUT_W);
        row_next = pos_prod[DIV_SHIFT +: ROW_W];
        col_rem  = pix_reg - PIX_W'(row_next * OUT_W);
    end

    assign ch_wrap = (ch_cnt_reg == CH_W'(IN_C - 1));
    assign kc_wrap = (kc_cnt_reg == KC_W'(KERNEL - 1));

    // decode and address generation
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_reg <= addr_in[OUT_IDX_W-1:0];
        end
        if (cmd.div_ch) begin
            pix_reg <= pix_next;
            och_reg <= och_rem[OCH_W-1:0];
        end
        if (cmd.div_pos) begin
            row_reg <= row_next;
            col_reg <= col_rem[COL_W-1:0];
        end
        if (cmd.base) begin
            act_ptr_reg <= ACT_AW'((row_reg * IN_W + col_reg) * IN_C);
            wgt_ptr_reg <= WGT_AW'(och_reg);
            ch_cnt_reg  <= '0;
            kc_cnt_reg  <= '0;
            tap_cnt_reg <= '0;
        end else if (cmd.issue) begin
            wgt_ptr_reg <= wgt_ptr_reg + WGT_AW'(OUT_C);
            tap_cnt_reg <= tap_cnt_reg + TAP_W'(1);
            if (ch_wrap) begin
                ch_cnt_reg <= '0;
                kc_cnt_reg <= kc_wrap ? '0 : kc_cnt_reg + KC_W'(1);
            end else begin
                ch_cnt_reg <= ch_cnt_reg + CH_W'(1);
            end
            if (ch_wrap && kc_wrap) begin
                act_ptr_reg <= act_ptr_reg + ACT_AW'(ROW_JUMP);
            end else begin
                act_ptr_reg <= act_ptr_reg + ACT_AW'(1);
            end
        end
    end

    // multiply-accumulate pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    // product and wrapping accumulate, seeded with the bias
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'($signed(act_q_reg) * $signed(wgt_q_reg));
        if (cmd.base) begin
            acc_reg <= bias_mem[och_reg];
        end else if (v2_reg) begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // relu, then rounding term
    assign relu_s    = acc_reg[ACC_W-1] ? '0 : $signed(acc_reg);
    assign half_next = (shift_reg == '0) ? '0
                     : (WIDE_W'(1) <<< (shift_reg - SHIFT_W'(1)));

    // saturate to int8
    always_comb begin
        if (shifted_reg > WIDE_W'(SAT_MAX)) begin
            out_val_next = OUT_VAL_W'(SAT_MAX);
        end else if (shifted_reg < WIDE_W'(SAT_MIN)) begin
            out_val_next = OUT_VAL_W'(SAT_MIN);
        end else begin
            out_val_next = shifted_reg[OUT_VAL_W-1:0];
        end
    end

    // requantize stages
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            mprod_reg <= relu_s * mant_reg;
        end
        if (cmd.round) begin
            sum_reg <= mprod_reg + half_next;
        end
        if (cmd.shift) begin
            shifted_reg <= sum_reg >>> shift_reg;
        end
        if (cmd.emit) begin
            out_idx_reg <= pos_reg;
            out_val_reg <= out_val_next;
        end
    end

    // output register handshake
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_val_reg, out_idx_reg};

    // status
    assign st.pos_ok    = (addr_in < ADDR_W'(OUT_COUNT));
    assign st.last_tap  = (tap_cnt_reg == TAP_W'(TAPS - 1));
    assign st.pipe_busy = v1_reg || v2_reg;
    assign st.out_free  = !m_tvalid_reg || m_tready;

endmodule

@@ hdl/int8_conv2d_relu_requant.sv @@
// ----------------------------------------------------------------------------
// int8_conv2d_relu_requant
// Int8 valid 2-D convolution, 5x5 kernel over 6 input channels into 16 output
// channels, with bias, ReLU and Q31 requantization to int8.
// ----------------------------------------------------------------------------
// Load transactions (write activation, weight or bias) leave the sequencer in
// its idle state, so the block stays ready for the next transaction. A compute
// transaction occupies the block from acceptance to readiness for the next
// item: position decode and address setup, the single shared multiply-accumulate
// that walks the 5x5x6 window one tap per cycle through one read port on each
// store, pipeline drain and mantissa multiply, and rounding, shift and saturation.
// The result sits in an output register, so the block takes new transactions
// while it waits; a second result waits in the last stage until the first is
// taken. Compute positions at or above 1600 and writes beyond a store are
// dropped. Every store entry must be written before a compute reads it.
module int8_conv2d_relu_requant
    import i8conv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // addr[11:0], value[43:12], zero pad
    input  logic [ACTION_W-1:0]   s_tuser,   // action[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_index[10:0], out_value[18:11], pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t st;

    i8conv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    i8conv_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a new result never overwrites one that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result");

    // an in-range compute transaction makes the block busy
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == ACT_COMPUTE) && st.pos_ok) |=> !s_tready)
        else $error("block still ready after accepting a compute");

    // output valid rises only after the controller emits a result
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("output valid without an emitted result");

    // taps are only issued while no input is taken
    a_issue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !s_tready)
        else $error("tap issued while accepting input");

endmodule
